// ----- rtl/vdt_pkg.sv -----
package vdt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COORD_WIDTH = 32;
  localparam int XYZ         = 3;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int SRC_W   = 16;
  localparam int IN_CW   = 32;
  localparam int IDX_W   = 8;

  typedef struct packed {
    logic [SRC_W-1:0]       src;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            entry;
  } wr_t;

endpackage

// ----- rtl/vertex_dedup_table.sv -----
// Channel | Handshake            | Fields                                        | Direction
// --------+----------------------+-----------------------------------------------+----------
// input   | in_valid, in_stall   | in_restart, in_source_index, in_coord_x/y/z   | in
// result  | out_valid, out_stall | out_table_index, out_found, out_status        | out
// config  | cfg_wr_en            | cfg_wr_data (match_by_index)                  | in
//
// A transaction goes from idle through a scan of the stored entries, up to and including the
// matching one (no scan on restart or an empty table); done then moves the result out and returns to idle.
// The search walks the entry memory one entry per cycle through its single read port.
// Reset clears the entry count and the mode register; no clearing pass is needed.
// A new input transaction is taken while a finished result waits in the output register.
// A stalled result keeps the next finished search waiting until the output register frees.
module vertex_dedup_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  input  logic [vdt_pkg::SRC_W-1:0]     in_source_index,
  input  logic signed [vdt_pkg::IN_CW-1:0] in_coord_x,
  input  logic signed [vdt_pkg::IN_CW-1:0] in_coord_y,
  input  logic signed [vdt_pkg::IN_CW-1:0] in_coord_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vdt_pkg::IDX_W-1:0]     out_table_index,
  output logic                          out_found,
  output logic                          out_status,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [vdt_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [vdt_pkg::ADDR_W-1:0]   pos_r, pos_nxt;
  vdt_pkg::entry_t              key_r, key_nxt;
  vdt_pkg::entry_t              in_entry;
  logic [vdt_pkg::IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic                         res_found_r, res_found_nxt;
  logic                         res_status_r, res_status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [vdt_pkg::IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                         out_found_r, out_found_nxt;
  logic                         out_status_r, out_status_nxt;
  logic                         mode_r;
  logic                         in_accept;
  logic                         match;
  logic [vdt_pkg::ADDR_W-1:0]   rd_addr;
  vdt_pkg::wr_t                 wr;

  assign in_stall        = (state_r != S_IDLE);
  assign in_accept       = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_table_index = out_idx_r;
  assign out_found       = out_found_r;
  assign out_status      = out_status_r;

  assign in_entry.src = in_source_index;
  assign in_entry.x   = in_coord_x[vdt_pkg::COORD_WIDTH-1:0];
  assign in_entry.y   = in_coord_y[vdt_pkg::COORD_WIDTH-1:0];
  assign in_entry.z   = in_coord_z[vdt_pkg::COORD_WIDTH-1:0];

  vdt_entry_store u_store (
    .clk            (clk),
    .wr             (wr),
    .rd_addr        (rd_addr),
    .key            (key_r),
    .match_by_index (mode_r),
    .match          (match)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    res_idx_nxt    = res_idx_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_idx_nxt    = out_idx_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    rd_addr        = pos_r + vdt_pkg::ADDR_W'(1);
    wr.en          = 1'b0;
    wr.addr        = count_r[vdt_pkg::ADDR_W-1:0];
    wr.entry       = key_r;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_accept) begin
          key_nxt = in_entry;
          pos_nxt = '0;
          if (in_restart || (count_r == '0)) begin
            // Restart or empty table: the vertex goes straight to position zero.
            wr.en          = 1'b1;
            wr.addr        = '0;
            wr.entry       = in_entry;
            count_nxt      = vdt_pkg::CNT_W'(1);
            res_idx_nxt    = '0;
            res_found_nxt  = 1'b0;
            res_status_nxt = 1'b0;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          res_idx_nxt    = vdt_pkg::IDX_W'(pos_r);
          res_found_nxt  = 1'b1;
          res_status_nxt = 1'b0;
          state_nxt      = S_DONE;
        end else if (({1'b0, pos_r} + vdt_pkg::CNT_W'(1)) == count_r) begin
          res_found_nxt = 1'b0;
          if (count_r == vdt_pkg::CNT_W'(vdt_pkg::TABLE_DEPTH)) begin
            res_idx_nxt    = '0;
            res_status_nxt = 1'b1;
          end else begin
            wr.en          = 1'b1;
            count_nxt      = count_r + vdt_pkg::CNT_W'(1);
            res_idx_nxt    = vdt_pkg::IDX_W'(count_r);
            res_status_nxt = 1'b0;
          end
          state_nxt = S_DONE;
        end else begin
          pos_nxt = pos_r + vdt_pkg::ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = res_idx_r;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    res_idx_r    <= res_idx_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
  end

  // A full-table result never claims a match and always reports position zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> !out_found_r && (out_idx_r == '0))
    else $error("full result with match or nonzero index");

  // The entry count stays within the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= vdt_pkg::CNT_W'(vdt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // An append always advances the count to just past the written position.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> (count_r == ({1'b0, $past(wr.addr)} + vdt_pkg::CNT_W'(1))))
    else $error("entry count out of step with append");

  // The search only runs over a nonempty table.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r != '0))
    else $error("search over an empty table");

endmodule

// ----- rtl/vdt_entry_store.sv -----
module vdt_entry_store (
  input  logic                      clk,
  input  vdt_pkg::wr_t              wr,
  input  logic [vdt_pkg::ADDR_W-1:0] rd_addr,
  input  vdt_pkg::entry_t           key,
  input  logic                      match_by_index,
  output logic                      match
);

  vdt_pkg::entry_t mem [vdt_pkg::TABLE_DEPTH];
  vdt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  // The compare sees the registered read-port entry against the held key.
  always_comb begin
    if (match_by_index) begin
      match = (rd_data_r.src == key.src);
    end else begin
      match = (rd_data_r.x == key.x) && (rd_data_r.y == key.y) && (rd_data_r.z == key.z);
    end
  end

endmodule

// ----- verif/vertex_dedup_table_tb.sv -----
`timescale 1ns / 100ps

module vertex_dedup_table_tb;
  import vdt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic                    restart;
    logic [SRC_W-1:0]        src;
    logic signed [IN_CW-1:0] x;
    logic signed [IN_CW-1:0] y;
    logic signed [IN_CW-1:0] z;
  } vertex_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    logic             found;
    logic             full;
  } lookup_t;

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic                    in_restart      = 1'b0;
  logic [SRC_W-1:0]        in_source_index = '0;
  logic signed [IN_CW-1:0] in_coord_x      = '0;
  logic signed [IN_CW-1:0] in_coord_y      = '0;
  logic signed [IN_CW-1:0] in_coord_z      = '0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  logic [IDX_W-1:0]        out_table_index;
  logic                    out_found;
  logic                    out_status;
  logic                    cfg_wr_en       = 1'b0;
  logic                    cfg_wr_data     = 1'b0;

  vertex_dedup_table u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .in_source_index (in_source_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_table_index (out_table_index),
    .out_found       (out_found),
    .out_status      (out_status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the vertex table.
  logic [COORD_WIDTH-1:0] shadow_x   [TABLE_DEPTH];
  logic [COORD_WIDTH-1:0] shadow_y   [TABLE_DEPTH];
  logic [COORD_WIDTH-1:0] shadow_z   [TABLE_DEPTH];
  logic [SRC_W-1:0]       shadow_src [TABLE_DEPTH];
  int unsigned            shadow_count    = 0;
  logic                   shadow_by_index = 1'b0;

  vertex_t     vertex_queue[$];
  lookup_t     expected_lookups[$];
  vertex_t     cur_vertex;
  lookup_t     want;
  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  bit          no_idle        = 1'b0;

  function automatic lookup_t lookup_or_append(vertex_t v);
    lookup_t                r;
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
    logic [COORD_WIDTH-1:0] cz;
    bit                     hit;
    cx = v.x[COORD_WIDTH-1:0];
    cy = v.y[COORD_WIDTH-1:0];
    cz = v.z[COORD_WIDTH-1:0];
    r.index = '0;
    r.found = 1'b0;
    r.full  = 1'b0;
    hit     = 1'b0;
    if (v.restart) shadow_count = 0;
    // The lowest matching position wins, whatever mode stored the entry.
    for (int p = 0; p < shadow_count && !hit; p++) begin
      if (shadow_by_index ? (shadow_src[p] == v.src)
                          : (shadow_x[p] == cx && shadow_y[p] == cy && shadow_z[p] == cz)) begin
        hit     = 1'b1;
        r.index = p[IDX_W-1:0];
        r.found = 1'b1;
      end
    end
    if (!hit) begin
      if (shadow_count >= TABLE_DEPTH) begin
        r.full = 1'b1;
      end else begin
        shadow_x[shadow_count]   = cx;
        shadow_y[shadow_count]   = cy;
        shadow_z[shadow_count]   = cz;
        shadow_src[shadow_count] = v.src;
        r.index = shadow_count[IDX_W-1:0];
        shadow_count++;
      end
    end
    return r;
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic signed [IN_CW-1:0] pick_coord();
    logic signed [IN_CW-1:0] pool [4];
    pool[0] = 32'sh0000_0000;
    pool[1] = -32'sd1;
    pool[2] = 32'sh7FFF_FFFF;
    pool[3] = 32'sh8000_0000;
    // A small pool makes coordinate matches frequent.
    if ($urandom_range(9) < 7) return pool[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  task automatic push_vertex(input logic r, input logic [SRC_W-1:0] s,
                             input logic signed [IN_CW-1:0] x,
                             input logic signed [IN_CW-1:0] y,
                             input logic signed [IN_CW-1:0] z);
    vertex_t v;
    v.restart = r;
    v.src     = s;
    v.x       = x;
    v.y       = y;
    v.z       = z;
    vertex_queue.push_back(v);
    queued_count++;
  endtask

  task automatic push_random(input int n);
    logic [SRC_W-1:0] s;
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(9) < 6) ? SRC_W'($urandom_range(15)) : SRC_W'($urandom);
      push_vertex($urandom_range(15) == 0, s, pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  task automatic write_mode(input logic by_index);
    @(posedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_wr_data     <= by_index;
    shadow_by_index  = by_index;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (!(accepted_count == queued_count && expected_lookups.size() == 0 && !in_valid))
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input driver: holds the payload while stalled, then pauses per pick_gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_lookups.push_back(lookup_or_append(cur_vertex));
        accepted_count++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (vertex_queue.size() > 0) begin
          cur_vertex       = vertex_queue.pop_front();
          in_restart      <= cur_vertex.restart;
          in_source_index <= cur_vertex.src;
          in_coord_x      <= cur_vertex.x;
          in_coord_y      <= cur_vertex.y;
          in_coord_z      <= cur_vertex.z;
          in_valid        <= 1'b1;
          send_gap         = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          note_mismatch($sformatf("result with none expected: index %0d found %0b status %0b",
                                  out_table_index, out_found, out_status));
        end else begin
          want = expected_lookups.pop_front();
          if (out_table_index !== want.index || out_found !== want.found ||
              out_status !== want.full) begin
            note_mismatch($sformatf(
              "expected index %0d found %0b status %0b, got index %0d found %0b status %0b",
              want.index, want.found, want.full, out_table_index, out_found, out_status));
          end
        end
      end
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Coordinate mode: extremes, partial matches, duplicates and a restart.
    write_mode(1'b0);
    push_vertex(1'b0, 16'h0000, 32'sh0, 32'sh0, 32'sh0);
    push_vertex(1'b0, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1);
    push_vertex(1'b0, 16'h1234, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1);
    push_vertex(1'b0, 16'h0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
    push_vertex(1'b0, 16'hFFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
    push_vertex(1'b0, 16'h0000, 32'sh0, 32'sh0, 32'sh0);
    push_vertex(1'b1, 16'h0000, 32'sh0, 32'sh0, 32'sh0);
    push_vertex(1'b0, 16'h0007, 32'sh0, 32'sh0, 32'sh0);
    push_vertex(1'b0, 16'hFFFF, 32'sh1, 32'sh2, 32'sh3);
    wait_idle();

    // Index mode over entries stored in coordinate mode.
    write_mode(1'b1);
    push_vertex(1'b0, 16'hFFFF, 32'sh0, 32'sh0, 32'sh5);
    push_vertex(1'b0, 16'h0007, 32'sh0, 32'sh0, 32'sh0);
    push_vertex(1'b0, 16'h0000, 32'sh9, 32'sh9, 32'sh9);
    push_vertex(1'b1, 16'hFFFF, 32'sh1, 32'sh1, 32'sh1);
    push_vertex(1'b0, 16'hFFFF, 32'sh2, 32'sh2, 32'sh2);
    push_vertex(1'b0, 16'h8000, 32'sh3, 32'sh3, 32'sh3);
    wait_idle();

    // Fill the table, then overflow it and hit the top entries.
    write_mode(1'b0);
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_vertex(i == 0, SRC_W'(i * 3), IN_CW'(i), 32'sh8000_0000 | IN_CW'(i), -IN_CW'(i));
    for (int i = 0; i < 4; i++)
      push_vertex(1'b0, SRC_W'(i * 3), 32'sh1000 + IN_CW'(i), 32'sh0, 32'sh0);
    push_vertex(1'b0, 16'h0001, 32'sd255, 32'sh8000_00FF, -32'sd255);
    push_vertex(1'b0, 16'h0001, 32'sd254, 32'sh8000_00FE, -32'sd254);
    push_vertex(1'b0, 16'h0001, 32'sd0, 32'sh8000_0000, 32'sd0);
    wait_idle();
    write_mode(1'b1);
    push_vertex(1'b0, 16'd765, 32'sh0, 32'sh0, 32'sh0);
    push_vertex(1'b0, 16'h0001, 32'sh0, 32'sh0, 32'sh0);
    push_vertex(1'b0, 16'hFFFF, 32'sh0, 32'sh0, 32'sh0);
    push_vertex(1'b1, 16'h0001, 32'sh0, 32'sh0, 32'sh0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph % 2 == 0);
      no_idle = (ph == 3);
      push_random(60);
      wait_idle();
    end
    no_idle = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_lookups.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- vertex_dedup_table.f -----
rtl/vdt_pkg.sv
rtl/vdt_entry_store.sv
rtl/vertex_dedup_table.sv
verif/vertex_dedup_table_tb.sv
